// ===== hw/rtl/asd_pkg.sv =====
// ----------------------------------------------------------------------------
// asd_pkg - shared types and constants of the arithmetic symbol decoder
// Command and status codes used by the decoder.
// ----------------------------------------------------------------------------
package asd_pkg;

	typedef enum logic [2:0] {
		CMD_CLEAR  = 3'd0,
		CMD_WRITE  = 3'd1,
		CMD_BUILD  = 3'd2,
		CMD_START  = 3'd3,
		CMD_DECODE = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_INTERVAL = 2'd1,
		ST_OVERREAD = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	localparam logic [15:0] TOP_CODE  = 16'hffff;
	localparam logic [15:0] HALF_BIT  = 16'h8000;
	localparam logic [15:0] QTR_BIT   = 16'h4000;
	localparam logic [15:0] QTR_MASK  = 16'h3fff;
	localparam logic [7:0]  SYM_BIAS  = 8'h80;

endpackage

// ===== hw/rtl/arithmetic_symbol_decoder.sv =====
// ----------------------------------------------------------------------------
// arithmetic_symbol_decoder - static-model arithmetic symbol decoder
// Count and cumulative tables in RAM, serial divider, renormalising sequencer.
// ----------------------------------------------------------------------------
//  channel | dir | handshake        | payload
//  s_axis  | in  | tvalid/tready    | cmd, symbol_index, count, bit_window, bits_valid
//  m_axis  | out | tvalid/tready    | symbol, bits_used, status
//
// One transfer at a time. Clear sweeps the count table; build sweeps it into
// the cumulative table. Decode takes three divisions, a downward table search
// and renormalisation at one bit per cycle.
// Reset clears interval state; after reset a clearing pass zeroes both tables
// before the first input transfer is taken.
// A held result blocks the next input only while the output is stalled.
module arithmetic_symbol_decoder #(
	parameter int SYMBOL_COUNT = 256,
	parameter int WINDOW_BITS  = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// [2:0] cmd, [10:3] symbol_index, [18:11] count,
	// [18+WINDOW_BITS:19] bit_window, then 5 bits bits_valid, zero fill
	input  logic [((WINDOW_BITS+24+7)/8)*8-1:0] s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// [7:0] symbol, [12:8] bits_used, [14:13] status, [15] zero
	output logic [15:0]            m_axis_tdata
);

	localparam int IW  = $clog2(SYMBOL_COUNT + 1);
	localparam int CW  = (SYMBOL_COUNT > 256) ? 256 : SYMBOL_COUNT;
	localparam int SW  = $clog2(CW);
	localparam int UW  = $clog2(WINDOW_BITS + 1);
	localparam int BW  = $clog2(WINDOW_BITS);

	typedef enum logic [4:0] {
		S_INIT, S_IDLE, S_CLR, S_BLD_RD, S_BLD_WR, S_START_RD, S_START_WT,
		S_D_DIV0, S_D_WT0, S_SRCH, S_SRCH_WT, S_RL_WT, S_RH_WT,
		S_D_DIV1, S_D_WT1, S_D_DIV2, S_D_WT2, S_NARROW, S_RENORM, S_OUT
	} state_t;

	state_t state_q;

	// input fields
	logic [2:0]             in_cmd;
	logic [7:0]             in_sidx;
	logic [7:0]             in_cnt;
	logic [WINDOW_BITS-1:0] in_win;
	logic [4:0]             in_bv;
	assign in_cmd  = s_axis_tdata[2:0];
	assign in_sidx = s_axis_tdata[10:3];
	assign in_cnt  = s_axis_tdata[18:11];
	assign in_win  = s_axis_tdata[18+WINDOW_BITS:19];
	assign in_bv   = s_axis_tdata[23+WINDOW_BITS:19+WINDOW_BITS];

	logic [WINDOW_BITS-1:0] win_q;
	logic [UW-1:0]          avail_q;
	logic [15:0] low_q, high_q, val_q, tot_q;
	logic [15:0] nlow_q, nhigh_q;
	logic [16:0] range_q;
	logic [IW-1:0] idx_q;
	logic [15:0] acc_q, rl_q, rh_q, target_q;
	logic [39:0] top_q;
	logic [7:0]  sym_q;
	logic [UW-1:0] used_q;
	logic [1:0]  status_q;
	logic [15:0] out_q;

	// count memory
	logic            cnt_we;
	logic [SW-1:0]   cnt_addr;
	logic [7:0]      cnt_wd, cnt_rd;
	asd_ram #(.WIDTH(8), .DEPTH(CW)) u_cnt (
		.clk(clk), .we(cnt_we), .addr(cnt_addr), .wdata(cnt_wd), .rdata(cnt_rd)
	);

	// cumulative memory
	logic            cum_we;
	logic [IW-1:0]   cum_addr;
	logic [15:0]     cum_wd, cum_rd;
	asd_ram #(.WIDTH(16), .DEPTH(SYMBOL_COUNT + 1)) u_cum (
		.clk(clk), .we(cum_we), .addr(cum_addr), .wdata(cum_wd), .rdata(cum_rd)
	);

	// divider
	logic        div_start, div_done;
	logic [39:0] div_num, div_q;
	logic [16:0] div_den;
	asd_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_num),
		.divisor(div_den), .done(div_done), .quotient(div_q)
	);

	logic [IW-1:0] ptr_q;
	logic [15:0]   clamp_bv;

	assign clamp_bv = (32'(in_bv) > 32'(WINDOW_BITS)) ? 16'(WINDOW_BITS) : 16'(in_bv);

	// renormalisation step values
	logic [15:0] r_low, r_high, r_val;
	logic        r_stop;
	always_comb begin
		r_low  = low_q;
		r_high = high_q;
		r_val  = val_q;
		r_stop = 1'b0;
		if (((high_q ^ low_q) & asd_pkg::HALF_BIT) != 16'd0) begin
			if ((low_q & asd_pkg::QTR_BIT) == 16'd0 || (high_q & asd_pkg::QTR_BIT) != 16'd0)
				r_stop = 1'b1;
			r_val  = val_q ^ asd_pkg::QTR_BIT;
			r_low  = low_q & asd_pkg::QTR_MASK;
			r_high = high_q | asd_pkg::QTR_BIT;
		end
		r_low  = {r_low[14:0], 1'b0};
		r_high = {r_high[14:0], 1'b1};
	end

	logic [BW-1:0] bit_pos;
	logic          new_bit;
	assign bit_pos = BW'(UW'(WINDOW_BITS - 1) - used_q);
	assign new_bit = win_q[bit_pos];

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tdata  = out_q;

	// memory and divider drive
	always_comb begin
		cnt_we    = 1'b0;
		cnt_addr  = ptr_q[SW-1:0];
		cnt_wd    = 8'd0;
		cum_we    = 1'b0;
		cum_addr  = ptr_q;
		cum_wd    = 16'd0;
		div_start = 1'b0;
		div_num   = 40'd0;
		div_den   = range_q;
		unique case (state_q)
			S_INIT: begin
				cnt_we = (ptr_q < IW'(CW));
				cum_we = 1'b1;
			end
			S_CLR: cnt_we = 1'b1;
			S_IDLE: begin
				if (s_axis_tvalid && in_cmd == asd_pkg::CMD_WRITE
						&& 32'(in_sidx) < 32'(SYMBOL_COUNT)) begin
					cnt_we   = 1'b1;
					cnt_addr = in_sidx[SW-1:0];
					cnt_wd   = in_cnt;
				end
			end
			S_BLD_WR: begin
				cum_we = 1'b1;
				cum_wd = acc_q;
			end
			S_D_DIV0: begin
				div_start = 1'b1;
				div_num   = 40'(tot_q - 16'd1)
					+ 40'({16'd0, 16'(val_q - low_q)} * {16'd0, tot_q});
			end
			S_D_DIV1: begin
				div_start = 1'b1;
				div_num   = 40'({15'd0, range_q} * {16'd0, rh_q});
				div_den   = 17'(tot_q);
			end
			S_D_DIV2: begin
				div_start = 1'b1;
				div_num   = 40'({15'd0, range_q} * {16'd0, rl_q});
				div_den   = 17'(tot_q);
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_INIT;
			ptr_q         <= '0;
			low_q         <= '0;
			high_q        <= asd_pkg::TOP_CODE;
			val_q         <= '0;
			tot_q         <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			unique case (state_q)
				S_INIT: begin
					ptr_q <= ptr_q + IW'(1);
					if (ptr_q == IW'(SYMBOL_COUNT)) begin
						ptr_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_axis_tvalid) begin
						win_q    <= in_win;
						avail_q  <= UW'(clamp_bv);
						sym_q    <= '0;
						used_q   <= '0;
						status_q <= asd_pkg::ST_OK;
						ptr_q    <= '0;
						unique case (in_cmd)
							asd_pkg::CMD_CLEAR:  state_q <= S_CLR;
							asd_pkg::CMD_BUILD: begin
								acc_q   <= '0;
								state_q <= S_BLD_RD;
							end
							asd_pkg::CMD_START: begin
								ptr_q   <= IW'(SYMBOL_COUNT);
								state_q <= S_START_RD;
							end
							asd_pkg::CMD_DECODE: begin
								if (tot_q == 16'd0) begin
									status_q <= asd_pkg::ST_EMPTY;
									state_q  <= S_OUT;
								end else if (high_q < low_q || val_q < low_q
										|| val_q > high_q) begin
									status_q <= asd_pkg::ST_INTERVAL;
									state_q  <= S_OUT;
								end else begin
									range_q <= 17'(high_q) - 17'(low_q) + 17'd1;
									state_q <= S_D_DIV0;
								end
							end
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_CLR: begin
					ptr_q <= ptr_q + IW'(1);
					if (ptr_q == IW'(CW - 1))
						state_q <= S_OUT;
				end
				// cumulative entry 0 is written zero, then running sums
				S_BLD_RD: state_q <= S_BLD_WR;
				S_BLD_WR: begin
					acc_q <= acc_q + 16'(cnt_rd);
					ptr_q <= ptr_q + IW'(1);
					state_q <= (ptr_q == IW'(SYMBOL_COUNT)) ? S_OUT : S_BLD_RD;
				end
				S_START_RD: state_q <= S_START_WT;
				S_START_WT: begin
					if (avail_q < UW'(16)) begin
						status_q <= asd_pkg::ST_OVERREAD;
					end else begin
						low_q    <= '0;
						high_q   <= asd_pkg::TOP_CODE;
						val_q    <= win_q[WINDOW_BITS-1 -: 16];
						tot_q    <= cum_rd;
						used_q   <= UW'(16);
						if (cum_rd == 16'd0)
							status_q <= asd_pkg::ST_EMPTY;
					end
					state_q <= S_OUT;
				end
				S_D_DIV0: state_q <= S_D_WT0;
				S_D_WT0: begin
					if (div_done) begin
						target_q <= div_q[15:0];
						ptr_q    <= IW'(SYMBOL_COUNT - 1);
						state_q  <= S_SRCH;
					end
				end
				// downward search, one table read per step
				S_SRCH: state_q <= S_SRCH_WT;
				S_SRCH_WT: begin
					if (ptr_q != '0 && target_q < cum_rd) begin
						ptr_q   <= ptr_q - IW'(1);
						state_q <= S_SRCH;
					end else begin
						idx_q   <= ptr_q;
						ptr_q   <= ptr_q + IW'(1);
						rl_q    <= cum_rd;
						state_q <= S_RL_WT;
					end
				end
				S_RL_WT: state_q <= S_RH_WT;
				S_RH_WT: begin
					rh_q    <= cum_rd;
					sym_q   <= 8'(idx_q) + asd_pkg::SYM_BIAS;
					state_q <= S_D_DIV1;
				end
				S_D_DIV1: state_q <= S_D_WT1;
				S_D_WT1: begin
					if (div_done) begin
						top_q   <= 40'(low_q) + div_q;
						state_q <= S_D_DIV2;
					end
				end
				S_D_DIV2: state_q <= S_D_WT2;
				S_D_WT2: begin
					if (div_done) begin
						if (top_q <= 40'(low_q) + div_q || top_q - 40'd1 > 40'hffff) begin
							status_q <= asd_pkg::ST_INTERVAL;
							state_q  <= S_OUT;
						end else begin
							nlow_q  <= 16'(40'(low_q) + div_q);
							nhigh_q <= 16'(top_q - 40'd1);
							state_q <= S_NARROW;
						end
					end
				end
				S_NARROW: begin
					low_q   <= nlow_q;
					high_q  <= nhigh_q;
					state_q <= S_RENORM;
				end
				// one renormalising bit per cycle
				S_RENORM: begin
					if (r_stop) begin
						state_q <= S_OUT;
					end else if (r_high < r_low) begin
						low_q    <= r_low;
						high_q   <= r_high;
						val_q    <= r_val;
						status_q <= asd_pkg::ST_INTERVAL;
						state_q  <= S_OUT;
					end else if (used_q >= avail_q) begin
						low_q    <= r_low;
						high_q   <= r_high;
						val_q    <= r_val;
						status_q <= asd_pkg::ST_OVERREAD;
						state_q  <= S_OUT;
					end else begin
						low_q  <= r_low;
						high_q <= r_high;
						val_q  <= {r_val[14:0], new_bit};
						used_q <= used_q + UW'(1);
						if (r_low > {r_val[14:0], new_bit} || r_high < {r_val[14:0], new_bit}) begin
							status_q <= asd_pkg::ST_INTERVAL;
							state_q  <= S_OUT;
						end
					end
				end
				S_OUT: begin
					if (!m_axis_tvalid || m_axis_tready) begin
						out_q         <= {1'b0, status_q, 5'(used_q), sym_q};
						m_axis_tvalid <= 1'b1;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (m_axis_tvalid && m_axis_tready && state_q != S_OUT)
				m_axis_tvalid <= 1'b0;
		end
	end

	// checks
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !(state_q == S_RENORM)) else $error("busy while ready");
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RENORM |-> high_q >= low_q || status_q != asd_pkg::ST_OK)
		else $error("interval inverted in renormalisation");
	a_used: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= avail_q || state_q == S_IDLE || state_q == S_INIT)
		else $error("overread of window");

endmodule

// ===== hw/rtl/asd_ram.sv =====
// ----------------------------------------------------------------------------
// asd_ram - generic single-port synchronous RAM
// A write when we is set and a read of the same address every cycle; read data registered, old contents on a write.
// ----------------------------------------------------------------------------
module asd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end

endmodule

// ===== hw/rtl/asd_div.sv =====
// ----------------------------------------------------------------------------
// asd_div - serial restoring divider
// Unsigned 40-bit dividend by 17-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module asd_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [39:0] dividend,
	input  logic [16:0] divisor,
	output logic        done,
	output logic [39:0] quotient
);

	logic [39:0] quo_q;
	logic [17:0] rem_q;
	logic [16:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [17:0] trial;
	logic [18:0] diff;

	assign trial    = {rem_q[16:0], quo_q[39]};
	assign diff     = {1'b0, trial} - {2'b00, dvs_q};
	assign quotient = quo_q;

	// shift, trial subtract, restore
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				quo_q  <= dividend;
				rem_q  <= '0;
				dvs_q  <= divisor;
				cnt_q  <= 6'd40;
			end else if (busy_q) begin
				if (!diff[18]) begin
					rem_q <= diff[17:0];
					quo_q <= {quo_q[38:0], 1'b1};
				end else begin
					rem_q <= trial;
					quo_q <= {quo_q[38:0], 1'b0};
				end
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

endmodule
